FILE: sv/brb_pkg.sv
// brb_pkg: shared types and constants of the byte ring buffer line reader
`default_nettype none
package brb_pkg;

   localparam int STORE_DEPTH = 256;
   localparam int PTR_W = $clog2(STORE_DEPTH);
   localparam int LINE_CAP = 64;
   localparam int KEEP_W = $clog2(LINE_CAP);
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [6:0] MAX_LINE_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_LINE  = 2'd1,
      OP_SPAN  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] line_byte;
      logic       last;
      logic [7:0] span_start;
      logic [7:0] span_count;
      logic [7:0] free_slots;
   } rsp_type;

endpackage
`default_nettype wire

FILE: sv/brb_ram.sv
// brb_ram: generic single write port ram with registered read
`default_nettype none
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/brb_front.sv
// brb_front: request intake, decode and two-entry command queue
`default_nettype none
module brb_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_type,
   input  wire logic [7:0]       req_push_byte,
   output logic                  cmd_valid,
   output brb_pkg::cmd_type      cmd,
   input  wire logic             cmd_pop
);

   brb_pkg::cmd_type q_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;
   brb_pkg::cmd_type decoded;

   always_comb begin
      decoded.op = brb_pkg::op_type'(req_type);
      decoded.data = req_push_byte;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ cmd_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= decoded;
      end
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/brb_back.sv
// brb_back: pointer state, byte store and request execution
`default_nettype none
module brb_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [6:0]       csr_max_line,
   input  wire logic             cmd_valid,
   input  wire brb_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   input  wire logic             rsp_full,
   output logic                  rsp_push,
   output brb_pkg::rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD,
      ST_EMIT,
      ST_NL
   } state_type;

   localparam int PW = brb_pkg::PTR_W;
   localparam int KW = brb_pkg::KEEP_W;

   state_type     state_ff, state_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] base_ff, base_in;
   logic [PW-1:0] iss_ff, iss_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          dv_ff, dv_in;
   logic [KW-1:0] ecnt_ff, ecnt_in;
   logic [KW-1:0] eidx_ff, eidx_in;
   logic [6:0]    max_line_ff;

   logic [6:0]    lim;
   logic [KW-1:0] keep;
   logic [PW-1:0] occ;
   logic [PW-1:0] next_wp;
   logic          found;

   logic          ram_we;
   logic [PW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_re;
   logic [PW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   brb_ram #(.WIDTH(8), .DEPTH(brb_pkg::STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // line limit saturates at the cap; 0 and 1 keep nothing
   always_comb begin
      lim = (max_line_ff > 7'(brb_pkg::LINE_CAP)) ? 7'(brb_pkg::LINE_CAP) : max_line_ff;
      keep = (lim == 7'd0) ? '0 : KW'(lim - 7'd1);
   end

   assign occ = wp_ff - rp_ff;
   assign next_wp = wp_ff + PW'(1);
   assign found = dv_ff && (ram_rdata == brb_pkg::NEWLINE_CODE);

   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      base_in = base_ff;
      iss_in = iss_ff;
      pos_in = pos_ff;
      dv_in = dv_ff;
      ecnt_in = ecnt_ff;
      eidx_in = eidx_ff;
      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      rsp_data.last = 1'b1;
      ram_we = 1'b0;
      ram_waddr = wp_ff;
      ram_wdata = cmd.data;
      ram_re = 1'b0;
      ram_raddr = rp_ff + iss_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  brb_pkg::OP_PUSH: begin
                     rsp_push = 1'b1;
                     if (next_wp != rp_ff) begin
                        ram_we = 1'b1;
                        wp_in = next_wp;
                        rsp_data.ok = 1'b1;
                     end
                  end
                  brb_pkg::OP_LINE: begin
                     state_in = ST_SCAN;
                     iss_in = '0;
                     dv_in = 1'b0;
                  end
                  brb_pkg::OP_SPAN: begin
                     rsp_push = 1'b1;
                     if (rp_ff != wp_ff) begin
                        rsp_data.ok = 1'b1;
                        rsp_data.span_start = 8'(rp_ff);
                        if (wp_ff > rp_ff) begin
                           rsp_data.span_count = 8'(wp_ff - rp_ff);
                           rp_in = wp_ff;
                        end else begin
                           // span runs to the end of the store
                           rsp_data.span_count = 8'(PW'(0) - rp_ff);
                           rp_in = '0;
                        end
                     end
                  end
                  brb_pkg::OP_CLEAR: begin
                     rsp_push = 1'b1;
                     rsp_data.ok = 1'b1;
                     wp_in = '0;
                     rp_in = '0;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (found) begin
               base_in = rp_ff;
               rp_in = rp_ff + pos_ff + PW'(1);
               eidx_in = '0;
               ecnt_in = (pos_ff < PW'(keep)) ? KW'(pos_ff) : keep;
               state_in = ((pos_ff < PW'(keep)) ? KW'(pos_ff) : keep) == '0 ? ST_NL : ST_RD;
            end else if (iss_ff == occ && !dv_ff) begin
               // every byte checked, no newline
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (iss_ff != occ) begin
               ram_re = 1'b1;
               iss_in = iss_ff + PW'(1);
               pos_in = iss_ff;
               dv_in = 1'b1;
            end else begin
               dv_in = 1'b0;
            end
         end
         ST_RD: begin
            ram_re = 1'b1;
            ram_raddr = base_ff + PW'(eidx_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_data.ok = 1'b1;
               rsp_data.last = 1'b0;
               rsp_data.line_byte = ram_rdata;
               eidx_in = eidx_ff + KW'(1);
               state_in = (eidx_ff + KW'(1) == ecnt_ff) ? ST_NL : ST_RD;
            end
         end
         ST_NL: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_data.ok = 1'b1;
               rsp_data.line_byte = brb_pkg::NEWLINE_CODE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // free count after the request
      rsp_data.free_slots = 8'(rp_in - wp_in - PW'(1));
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      iss_ff <= iss_in;
      pos_ff <= pos_in;
      ecnt_ff <= ecnt_in;
      eidx_ff <= eidx_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff <= '0;
         rp_ff <= '0;
         dv_ff <= 1'b0;
         max_line_ff <= brb_pkg::MAX_LINE_RESET;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         dv_ff <= dv_in;
         if (csr_valid && csr_ready) begin
            max_line_ff <= csr_max_line;
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/brb_rspq.sv
// brb_rspq: two-entry result queue driving the response channel
`default_nettype none
module brb_rspq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rsp_push,
   input  wire brb_pkg::rsp_type rsp_data,
   output logic                  rsp_full,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output brb_pkg::rsp_type      rsp_head
);

   brb_pkg::rsp_type q_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             pop;

   assign rsp_full = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_head = q_ff[rd_ff];
   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      wr_in = wr_ff ^ rsp_push;
      rd_in = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, rsp_push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         q_ff[wr_ff] <= rsp_data;
      end
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/byte_ring_buffer_line_reader.sv
// byte_ring_buffer_line_reader: top level of the ring buffer with line reads
//
//  channel | dir | handshake         | beat
//  req     | in  | req_valid/stall   | req_type, req_push_byte
//  rsp     | out | rsp_valid/stall   | ok, line_byte, last, span_start, span_count, free_slots
//  csr     | in  | csr_valid/ready   | csr_max_line (always ready)
//
// push, take-span and clear complete in idle, so pushes stream at one per cycle while no
// line read runs and the result queue has room. a line read scans one stored byte per cycle
// through the store's read port, then emits each kept byte (read, send) and the newline.
// reset (synchronous) empties the ring and sets max_line to 64; store contents are kept.
// a two-entry command queue and a two-entry result queue let either side stall alone.
`default_nettype none
module byte_ring_buffer_line_reader (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_push_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_ok,
   output logic [7:0]       rsp_line_byte,
   output logic             rsp_last,
   output logic [7:0]       rsp_span_start,
   output logic [7:0]       rsp_span_count,
   output logic [7:0]       rsp_free_slots,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_max_line
);

   logic             cmd_valid;
   brb_pkg::cmd_type cmd;
   logic             cmd_pop;
   logic             rsp_full;
   logic             rsp_push;
   brb_pkg::rsp_type rsp_data;
   brb_pkg::rsp_type rsp_head;

   assign csr_ready = 1'b1;

   brb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_push_byte (req_push_byte),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   brb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_max_line (csr_max_line),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .rsp_full     (rsp_full),
      .rsp_push     (rsp_push),
      .rsp_data     (rsp_data)
   );

   brb_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_head  (rsp_head)
   );

   assign rsp_ok = rsp_head.ok;
   assign rsp_line_byte = rsp_head.line_byte;
   assign rsp_last = rsp_head.last;
   assign rsp_span_start = rsp_head.span_start;
   assign rsp_span_count = rsp_head.span_count;
   assign rsp_free_slots = rsp_head.free_slots;

endmodule
`default_nettype wire

FILE: sv/brb_check.sv
// brb_check: port-level checks of the line reader, bound to the top level
`default_nettype none
module brb_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_ok,
   input wire logic [7:0] rsp_line_byte,
   input wire logic       rsp_last,
   input wire logic [7:0] rsp_span_start,
   input wire logic [7:0] rsp_span_count
);

   // a stalled beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_byte) && $stable(rsp_last))
      else $error("stalled response beat changed");

   // only line bytes come without last, and they are successes
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_ok)
      else $error("non-final beat without ok");

   a_mid_nospan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_span_count == 8'd0 && rsp_span_start == 8'd0)
      else $error("line byte beat carries span fields");

   // a span result is final and carries no line byte
   a_span_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_count != 8'd0 |-> rsp_ok && rsp_last && rsp_line_byte == 8'd0)
      else $error("span beat malformed");

   // a failed request carries no line byte and no span count
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_last && rsp_line_byte == 8'd0 && rsp_span_count == 8'd0)
      else $error("failed request beat carries data");

endmodule

bind byte_ring_buffer_line_reader brb_check u_brb_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_ok         (rsp_ok),
   .rsp_line_byte  (rsp_line_byte),
   .rsp_last       (rsp_last),
   .rsp_span_start (rsp_span_start),
   .rsp_span_count (rsp_span_count)
);
`default_nettype wire
